FILE: hdl/sbfb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants, microcode table and CRC-8 step for the SMBus frame builder.
package sbfb_pkg;

	localparam int MAX_PAYLOAD_BYTES_DEF = 8;

	localparam logic [7:0] CRC_POLY        = 8'h07;
	localparam logic [7:0] CRC_MSB         = 8'h80;
	localparam logic [7:0] BYTE_ZERO       = 8'h00;
	localparam logic [7:0] LEN_BIAS        = 8'd3;
	localparam logic [7:0] FETCH_COUNT_RST = 8'd4;
	localparam logic [2:0] ASIZE_WIDE      = 3'd4;
	localparam logic [2:0] ASIZE_NARROW    = 3'd2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RADDR = 2'd1,
		OP_FETCH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_BRIDGE_BUS        = 3'd0,
		REG_TARGET_ADDR       = 3'd1,
		REG_WRITE_CMD         = 3'd2,
		REG_READ_START_WIDE   = 3'd3,
		REG_READ_END_WIDE     = 3'd4,
		REG_READ_START_NARROW = 3'd5,
		REG_READ_END_NARROW   = 3'd6,
		REG_FETCH_COUNT       = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		SRC_BUS  = 4'd0,
		SRC_TGT  = 4'd1,
		SRC_RCNT = 4'd2,
		SRC_CMD  = 4'd3,
		SRC_LEN  = 4'd4,
		SRC_ADDR = 4'd5,
		SRC_PAY  = 4'd6,
		SRC_CRC  = 4'd7,
		SRC_END  = 4'd8,
		SRC_ZERO = 4'd9
	} src_t;

	typedef enum logic [1:0] {
		CRC_HOLD = 2'd0,
		CRC_SEED = 2'd1,
		CRC_UPD  = 2'd2
	} crc_op_t;

	typedef enum logic [2:0] {
		COND_NEVER     = 3'd0,
		COND_FETCH     = 3'd1,
		COND_ADDR_MORE = 3'd2,
		COND_PAY_NONE  = 3'd3,
		COND_PAY_MORE  = 3'd4
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_BUS    = 4'd0;
	localparam step_t STEP_TGT    = 4'd1;
	localparam step_t STEP_RCNT   = 4'd2;
	localparam step_t STEP_CMD    = 4'd3;
	localparam step_t STEP_LEN    = 4'd4;
	localparam step_t STEP_ADDR   = 4'd5;
	localparam step_t STEP_PAYCHK = 4'd6;
	localparam step_t STEP_PAY    = 4'd7;
	localparam step_t STEP_CRC    = 4'd8;
	localparam step_t STEP_FEND   = 4'd9;
	localparam step_t STEP_ERR    = 4'd10;

	typedef struct packed {
		logic    emit;
		src_t    src;
		crc_op_t crc;
		logic    last;
		logic    err;
		cond_t   cond;
		step_t   jump;
	} ctrl_t;

	typedef struct packed {
		logic fetch;
		logic addr_more;
		logic pay_none;
		logic pay_more;
	} seq_stat_t;

	function automatic ctrl_t ucode_rom(input step_t s);
		ctrl_t w;
		w = '{emit: 1'b0, src: SRC_ZERO, crc: CRC_HOLD, last: 1'b1, err: 1'b0,
			cond: COND_NEVER, jump: STEP_BUS};
		case (s)
			STEP_BUS: w = '{1'b1, SRC_BUS, CRC_HOLD, 1'b0, 1'b0, COND_NEVER, STEP_BUS};
			STEP_TGT: w = '{1'b1, SRC_TGT, CRC_SEED, 1'b0, 1'b0, COND_NEVER, STEP_BUS};
			STEP_RCNT: w = '{1'b1, SRC_RCNT, CRC_HOLD, 1'b0, 1'b0, COND_FETCH, STEP_FEND};
			STEP_CMD: w = '{1'b1, SRC_CMD, CRC_UPD, 1'b0, 1'b0, COND_NEVER, STEP_BUS};
			STEP_LEN: w = '{1'b1, SRC_LEN, CRC_UPD, 1'b0, 1'b0, COND_NEVER, STEP_BUS};
			STEP_ADDR: w = '{1'b1, SRC_ADDR, CRC_UPD, 1'b0, 1'b0, COND_ADDR_MORE, STEP_ADDR};
			STEP_PAYCHK: w = '{1'b0, SRC_ZERO, CRC_HOLD, 1'b0, 1'b0, COND_PAY_NONE, STEP_CRC};
			STEP_PAY: w = '{1'b1, SRC_PAY, CRC_UPD, 1'b0, 1'b0, COND_PAY_MORE, STEP_PAY};
			STEP_CRC: w = '{1'b1, SRC_CRC, CRC_HOLD, 1'b1, 1'b0, COND_NEVER, STEP_BUS};
			STEP_FEND: w = '{1'b1, SRC_END, CRC_HOLD, 1'b1, 1'b0, COND_NEVER, STEP_BUS};
			STEP_ERR: w = '{1'b1, SRC_ZERO, CRC_HOLD, 1'b1, 1'b1, COND_NEVER, STEP_BUS};
			default: w = '{1'b0, SRC_ZERO, CRC_HOLD, 1'b1, 1'b0, COND_NEVER, STEP_BUS};
		endcase
		return w;
	endfunction

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != BYTE_ZERO) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: hdl/sbfb_crc.sv
`timescale 1ns / 1ps
// PEC accumulator: CRC-8 register seeded from the write address byte, one byte per update.
module sbfb_crc
	import sbfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  crc_op_t    op,
	input  logic [6:0] tgt,
	input  logic [7:0] data,
	output logic [7:0] crc
);

	logic [7:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= BYTE_ZERO;
		end else if (fire) begin
			case (op)
				CRC_SEED: crc_q <= crc8_byte(BYTE_ZERO, {tgt, 1'b0});
				CRC_UPD:  crc_q <= crc8_byte(crc_q, data);
				default:  crc_q <= crc_q;
			endcase
		end
	end

	assign crc = crc_q;

endmodule

FILE: hdl/sbfb_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store fetch and conditional branching.
module sbfb_seq
	import sbfb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  step_t     start_step,
	input  logic      out_free,
	input  seq_stat_t stat,
	output ctrl_t     ctrl,
	output logic      fire,
	output logic      busy
);

	logic  busy_q;
	step_t step_q;
	logic  take;

	assign ctrl = ucode_rom(step_q);
	assign fire = busy_q && (!ctrl.emit || out_free);
	assign busy = busy_q;

	always_comb begin
		case (ctrl.cond)
			COND_FETCH:     take = stat.fetch;
			COND_ADDR_MORE: take = stat.addr_more;
			COND_PAY_NONE:  take = stat.pay_none;
			COND_PAY_MORE:  take = stat.pay_more;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_BUS;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= start_step;
		end else if (fire) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else if (take) begin
				step_q <= ctrl.jump;
			end else begin
				step_q <= step_q + step_t'(1);
			end
		end
	end

endmodule

FILE: hdl/smbus_bridge_frame_builder_pec_unit.sv
`timescale 1ns / 1ps
// Top level of the SMBus bridge frame builder with PEC: registers, datapath, output stage.
//
// Usage: one request enters on the input channel (in_valid / in_stall); the frame leaves
// one byte per transaction on the output channel (out_valid / out_stall), last_byte set on
// the final byte. A bad address length gives one byte 0 with last_byte and size_error set;
// opcode 3 is taken and dropped with no output.
// A microcoded sequencer walks a small control store, one step per cycle unless out_stall
// holds it; each emitting step sends one byte through a single output register, so
// throughput is at most one byte per cycle. After a request is accepted the sequencer
// starts, and its first step then loads the first byte into the output register.
// Each request passes through the accept, one sequencer step per frame byte, and one
// payload-check step that emits nothing in write and read-address frames.
// in_stall is high while a frame is in progress; the next request may be taken while the
// final byte still sits in the output register.
// When out_stall is high with a byte valid, the output register holds and the sequencer waits on its next
// emitting step. Reset clears the sequencer and output valid, and sets the configuration
// registers to their defaults (fetch count 4, all others 0). Configuration is written
// through cfg_we / cfg_index / cfg_data; write it only while the block is idle.
module smbus_bridge_frame_builder_pec_unit
	import sbfb_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] reg_address,
	input  logic [2:0]  address_bytes,
	input  logic [63:0] payload_data,
	input  logic [3:0]  payload_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte,
	output logic        size_error
);

	localparam int PIW = $clog2(MAX_PAYLOAD_BYTES + 1);

	logic [6:0] bus_q;
	logic [6:0] tgt_q;
	logic [7:0] wcmd_q;
	logic [7:0] rsw_q;
	logic [7:0] rew_q;
	logic [7:0] rsn_q;
	logic [7:0] ren_q;
	logic [7:0] fcnt_q;

	op_t            op_q;
	logic [2:0]     asize_q;
	logic [31:0]    addr_q;
	logic [63:0]    pay_q;
	logic [2:0]     arem_q;
	logic [PIW-1:0] prem_q;

	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        err_q;

	logic           accept;
	logic           start;
	logic           bad_size;
	step_t          start_step;
	logic           out_free;
	logic           fire;
	logic           busy;
	ctrl_t          ctrl;
	seq_stat_t      stat;
	logic [7:0]     crc;
	logic [7:0]     sel_byte;
	logic           wide;
	logic [PIW-1:0] psize_sat;
	op_t            op_in;

	assign op_in    = op_t'(opcode);
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (op_in != OP_NONE);
	assign bad_size = (op_in == OP_WRITE) ? (address_bytes != ASIZE_WIDE)
		: ((address_bytes != ASIZE_NARROW) && (address_bytes != ASIZE_WIDE));
	assign start_step = bad_size ? STEP_ERR : STEP_BUS;
	assign in_stall = busy;
	assign out_free = !out_valid_q || !out_stall;
	assign wide     = (asize_q == ASIZE_WIDE);

	always_comb begin
		if ({{PIW{1'b0}}, payload_bytes} > (PIW + 4)'(MAX_PAYLOAD_BYTES)) begin
			psize_sat = PIW'(MAX_PAYLOAD_BYTES);
		end else begin
			psize_sat = PIW'(payload_bytes);
		end
	end

	assign stat.fetch     = (op_q == OP_FETCH);
	assign stat.addr_more = (arem_q != 3'd1);
	assign stat.pay_none  = (prem_q == '0);
	assign stat.pay_more  = (prem_q != PIW'(1));

	sbfb_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_step (start_step),
		.out_free   (out_free),
		.stat       (stat),
		.ctrl       (ctrl),
		.fire       (fire),
		.busy       (busy)
	);

	always_comb begin
		case (ctrl.src)
			SRC_BUS:  sel_byte = {bus_q, 1'b1};
			SRC_TGT:  sel_byte = {1'b0, tgt_q};
			SRC_RCNT: sel_byte = (op_q == OP_FETCH) ? fcnt_q : BYTE_ZERO;
			SRC_CMD:  sel_byte = (op_q == OP_WRITE) ? wcmd_q : (wide ? rsw_q : rsn_q);
			SRC_LEN:  sel_byte = (op_q == OP_WRITE)
				? (8'(prem_q) + 8'(asize_q) + LEN_BIAS) : 8'(asize_q);
			SRC_ADDR: sel_byte = addr_q[7:0];
			SRC_PAY:  sel_byte = pay_q[7:0];
			SRC_CRC:  sel_byte = crc;
			SRC_END:  sel_byte = wide ? rew_q : ren_q;
			default:  sel_byte = BYTE_ZERO;
		endcase
	end

	sbfb_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (ctrl.crc),
		.tgt    (tgt_q),
		.data   (sel_byte),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q  <= '0;
			tgt_q  <= '0;
			wcmd_q <= '0;
			rsw_q  <= '0;
			rew_q  <= '0;
			rsn_q  <= '0;
			ren_q  <= '0;
			fcnt_q <= FETCH_COUNT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_BRIDGE_BUS:        bus_q  <= cfg_data[6:0];
				REG_TARGET_ADDR:       tgt_q  <= cfg_data[6:0];
				REG_WRITE_CMD:         wcmd_q <= cfg_data;
				REG_READ_START_WIDE:   rsw_q  <= cfg_data;
				REG_READ_END_WIDE:     rew_q  <= cfg_data;
				REG_READ_START_NARROW: rsn_q  <= cfg_data;
				REG_READ_END_NARROW:   ren_q  <= cfg_data;
				REG_FETCH_COUNT:       fcnt_q <= cfg_data;
				default:               fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_NONE;
			arem_q <= '0;
			prem_q <= '0;
		end else if (start) begin
			op_q   <= op_in;
			arem_q <= address_bytes;
			prem_q <= (op_in == OP_WRITE) ? psize_sat : '0;
		end else if (fire) begin
			if (ctrl.src == SRC_ADDR) begin
				arem_q <= arem_q - 3'd1;
			end
			if (ctrl.src == SRC_PAY) begin
				prem_q <= prem_q - PIW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			asize_q <= address_bytes;
			addr_q  <= reg_address;
			pay_q   <= payload_data;
		end else if (fire) begin
			if (ctrl.src == SRC_ADDR) begin
				addr_q <= addr_q >> 8;
			end
			if (ctrl.src == SRC_PAY) begin
				pay_q <= pay_q >> 8;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctrl.emit) begin
			byte_q <= sel_byte;
			last_q <= ctrl.last;
			err_q  <= ctrl.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;
	assign size_error = err_q;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && size_error |-> last_byte && (frame_byte == BYTE_ZERO))
		else $error("error result not a single zero byte");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("request accepted without entering frame");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && ctrl.emit && out_valid_q && out_stall))
		else $error("held output byte overwritten");

	a_addr_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy && (ctrl.src == SRC_ADDR) |-> (arem_q != 3'd0) && (arem_q <= ASIZE_WIDE))
		else $error("address byte counter out of range");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !(out_valid && !$past(out_valid)))
		else $error("output byte produced while idle");

endmodule
